FILE: rtl/odo_pkg.sv
// Shared types, command codes and constants for the odometry integrator.
// No dependencies.
package odo_pkg;

  localparam logic [1:0] CMD_TWIST = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam int MAG_W  = 56;
  localparam int NUM_W  = 51;  // magnitude with the 2^5 factor of 500000 shifted out
  localparam int DIG_W  = 17;
  localparam int DIGITS = 3;
  localparam int REM_W  = 14;
  localparam int VAL_W  = 31;
  localparam int PROD_W = 63;
  localparam int DIV_SH = 45;
  localparam logic [REM_W-1:0] DIV_D = 14'd15625;       // 500000 / 32
  localparam logic [31:0]      DIV_M = 32'd2251799814;  // ceil(2^45 / 15625)
  localparam int CW = 34;
  localparam int SC_W = 20;
  localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;

  localparam logic [2:0] REG_METHOD = 3'd0;

  typedef struct packed {
    logic        is_twist;
    logic        is_set;
    logic [31:0] stamp_us;
    logic [23:0] lin_velocity;
    logic [23:0] ang_velocity;
    logic [31:0] set_x;
    logic [31:0] set_y;
    logic [15:0] set_heading;
  } odo_item_t;

  function automatic logic [29:0] atan_at(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:  a = 30'd536870912;
      5'd1:  a = 30'd316933406;
      5'd2:  a = 30'd167458907;
      5'd3:  a = 30'd85004756;
      5'd4:  a = 30'd42667331;
      5'd5:  a = 30'd21354465;
      5'd6:  a = 30'd10679838;
      5'd7:  a = 30'd5340245;
      5'd8:  a = 30'd2670163;
      5'd9:  a = 30'd1335087;
      5'd10: a = 30'd667544;
      5'd11: a = 30'd333772;
      5'd12: a = 30'd166886;
      5'd13: a = 30'd83443;
      5'd14: a = 30'd41722;
      5'd15: a = 30'd20861;
      5'd16: a = 30'd10430;
      5'd17: a = 30'd5215;
      5'd18: a = 30'd2608;
      5'd19: a = 30'd1304;
      5'd20: a = 30'd652;
      5'd21: a = 30'd326;
      5'd22: a = 30'd163;
      5'd23: a = 30'd81;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/odo_ifs.sv
// Valid/ready channel interfaces for twist items and pose results.
// No dependencies.
interface odo_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] stamp_us;
  logic signed [23:0] lin_velocity;
  logic signed [23:0] ang_velocity;
  logic signed [31:0] set_x;
  logic signed [31:0] set_y;
  logic [15:0] set_heading;
  modport source(output valid, cmd, stamp_us, lin_velocity, ang_velocity, set_x, set_y,
                 set_heading, input ready);
  modport sink(input valid, cmd, stamp_us, lin_velocity, ang_velocity, set_x, set_y,
               set_heading, output ready);
endinterface

interface odo_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0] heading;
  modport source(output valid, pos_x, pos_y, heading, input ready);
  modport sink(input valid, pos_x, pos_y, heading, output ready);
endinterface

FILE: rtl/odo_front.sv
// Front end: accepts beats, drops unused commands, queues items (two deep).
// Depends on odo_pkg.
module odo_front import odo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  odo_item_t   in_item,
  output logic        q_valid,
  output odo_item_t   q_item,
  input  logic        q_pop
);

  odo_item_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready &&
                    (in_cmd == CMD_TWIST || in_cmd == CMD_SET || in_cmd == CMD_RESET);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: rtl/odo_div.sv
// Two parallel dividers by 500000: long division in 17-bit digits, each digit
// by reciprocal multiply (a multiply phase, then a commit phase). Depends on odo_pkg.
module odo_div import odo_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] mag_v,
  input  logic [MAG_W-1:0] mag_w,
  output logic             done,
  output logic [MAG_W-1:0] quo_v,
  output logic [MAG_W-1:0] quo_w
);

  logic [NUM_W-1:0]  nv_r, nw_r, qv_r, qw_r;
  logic [REM_W-1:0]  rv_r, rw_r;
  logic [PROD_W-1:0] pv_r, pw_r;
  logic [VAL_W-1:0]  vv, vw, mv, mw;
  logic [DIG_W-1:0]  dv, dw;
  logic [1:0]        cnt_r;
  logic              ph_r, busy_r, done_r;

  always_comb begin
    vv = {rv_r, nv_r[NUM_W-1 -: DIG_W]};
    vw = {rw_r, nw_r[NUM_W-1 -: DIG_W]};
    dv = pv_r[DIV_SH +: DIG_W];
    dw = pw_r[DIV_SH +: DIG_W];
    mv = vv - VAL_W'(dv) * VAL_W'(DIV_D);
    mw = vw - VAL_W'(dw) * VAL_W'(DIV_D);
  end

  assign done  = done_r;
  assign quo_v = {{(MAG_W-NUM_W){1'b0}}, qv_r};
  assign quo_w = {{(MAG_W-NUM_W){1'b0}}, qw_r};

  always_ff @(posedge clk) begin
    if (start) begin
      nv_r <= mag_v[MAG_W-1 -: NUM_W];
      nw_r <= mag_w[MAG_W-1 -: NUM_W];
      rv_r <= '0;
      rw_r <= '0;
      qv_r <= '0;
      qw_r <= '0;
    end else if (busy_r && !ph_r) begin
      pv_r <= PROD_W'(vv) * PROD_W'(DIV_M);
      pw_r <= PROD_W'(vw) * PROD_W'(DIV_M);
    end else if (busy_r) begin
      nv_r <= nv_r << DIG_W;
      nw_r <= nw_r << DIG_W;
      rv_r <= mv[REM_W-1:0];
      rw_r <= mw[REM_W-1:0];
      qv_r <= {qv_r[NUM_W-DIG_W-1:0], dv};
      qw_r <= {qw_r[NUM_W-DIG_W-1:0], dw};
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= 1'b0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        ph_r <= ~ph_r;
        if (ph_r) begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'(DIGITS - 1)) busy_r <= 1'b0;
        end
      end
      done_r <= !start && busy_r && ph_r && (cnt_r == 2'(DIGITS - 1));
    end
  end

endmodule

FILE: rtl/odo_cordic.sv
// Iterative rotation-mode CORDIC, one step per cycle, with quadrant fold.
// Depends on odo_pkg.
module odo_cordic import odo_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [15:0]            angle,
  output logic                   done,
  output logic signed [SC_W-1:0] cos_q16,
  output logic signed [SC_W-1:0] sin_q16
);

  localparam int IW = $clog2(STEPS);

  logic signed [CW-1:0] x_r, y_r, z_r, xs, ys, at;
  logic signed [CW-1:0] xp, yp;
  logic [1:0]           q_r;
  logic [IW-1:0]        i_r;
  logic                 busy_r, fin_r;
  logic signed [SC_W-1:0] xr, yr;

  always_comb begin
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = $signed({4'b0, atan_at(5'(i_r))});
    xp = x_r + 34'sd8192;
    yp = y_r + 34'sd8192;
    xr = xp[CW-1:14];
    yr = yp[CW-1:14];
    case (q_r)
      2'd0: begin cos_q16 = xr;  sin_q16 = yr;  end
      2'd1: begin cos_q16 = -yr; sin_q16 = xr;  end
      2'd2: begin cos_q16 = -xr; sin_q16 = -yr; end
      default: begin cos_q16 = yr; sin_q16 = -xr; end
    endcase
  end

  assign done = fin_r;

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= CORDIC_START;
      y_r <= '0;
      z_r <= $signed({4'b0, angle[13:0], 16'b0});
      q_r <= angle[15:14];
    end else if (busy_r) begin
      if (!z_r[CW-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      i_r    <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        i_r <= i_r + 1'b1;
        if (i_r == IW'(STEPS - 1)) busy_r <= 1'b0;
      end
      fin_r <= !start && busy_r && (i_r == IW'(STEPS - 1));
    end
  end

endmodule

FILE: rtl/odo_back.sv
// Back end: sequences one queued twist item through multiply, divide, CORDIC and
// pose update; holds the pose state and the result register. Depends on odo_pkg.
module odo_back import odo_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        method,
  input  logic        q_valid,
  input  odo_item_t   q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [15:0] out_h
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DST  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_ANG  = 3'd4;
  localparam logic [2:0] S_CORD = 3'd5;
  localparam logic [2:0] S_PROD = 3'd6;
  localparam logic [2:0] S_UPD  = 3'd7;

  logic [2:0]  state_r;
  logic [31:0] prev_stamp_r, stamp_r, dt_r;
  logic [23:0] prev_lin_r, prev_ang_r, lin_r, ang_r;
  logic [31:0] x_r, y_r;
  logic [15:0] hd_r, dh_r, half_r;
  logic signed [56:0] pv_r, pw_r, npv, npw;
  logic signed [37:0] d_r;
  logic signed [SC_W-1:0] c_r, s_r;
  logic signed [57:0] px_r, py_r;
  logic [47:0] rx, ry;
  logic        out_valid_r;
  logic [31:0] out_x_r, out_y_r;
  logic [15:0] out_h_r;

  logic             div_start, div_done, cor_start, cor_done;
  logic [MAG_W-1:0] qv, qw;
  logic [MAG_W:0]   qv1, qw1, qw2;
  logic [36:0]      dmag;
  logic [15:0]      dhmag, halfmag;
  logic signed [SC_W-1:0] cos_w, sin_w;
  logic [15:0]      ang;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign div_start = (state_r == S_DST);
  assign cor_start = (state_r == S_ANG);
  assign npv = -pv_r;
  assign npw = -pw_r;
  assign ang = method ? hd_r + half_r : hd_r;
  assign qv1 = {1'b0, qv} + 57'd1;
  assign qw1 = {1'b0, qw} + 57'd1;
  assign qw2 = {1'b0, qw} + 57'd2;
  assign dmag    = qv1[37:1];
  assign dhmag   = qw1[16:1];
  assign halfmag = qw2[17:2];
  assign rx = px_r[47:0] + 48'd32768;
  assign ry = py_r[47:0] + 48'd32768;

  assign out_valid = out_valid_r;
  assign out_x = out_x_r;
  assign out_y = out_y_r;
  assign out_h = out_h_r;

  odo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag_v (pv_r[56] ? npv[MAG_W-1:0] : pv_r[MAG_W-1:0]),
    .mag_w (pw_r[56] ? npw[MAG_W-1:0] : pw_r[MAG_W-1:0]),
    .done  (div_done),
    .quo_v (qv),
    .quo_w (qw)
  );

  odo_cordic #(.STEPS(STEPS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .angle   (ang),
    .done    (cor_done),
    .cos_q16 (cos_w),
    .sin_q16 (sin_w)
  );

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        stamp_r <= q_item.stamp_us;
        lin_r   <= q_item.lin_velocity;
        ang_r   <= q_item.ang_velocity;
        dt_r    <= q_item.stamp_us - prev_stamp_r;
      end
      S_MUL: begin
        pv_r <= 57'($signed(prev_lin_r) * $signed({1'b0, dt_r}));
        pw_r <= 57'($signed(prev_ang_r) * $signed({1'b0, dt_r}));
      end
      S_DIV: begin
        d_r    <= pv_r[56] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
        dh_r   <= pw_r[56] ? -dhmag : dhmag;
        half_r <= pw_r[56] ? -halfmag : halfmag;
      end
      S_CORD: begin
        c_r <= cos_w;
        s_r <= sin_w;
      end
      S_PROD: begin
        px_r <= 58'(d_r * c_r);
        py_r <= 58'(d_r * s_r);
      end
      default: ;
    endcase
    if (state_r == S_UPD && (!out_valid_r || out_ready)) begin
      out_x_r <= x_r + rx[47:16];
      out_y_r <= y_r + ry[47:16];
      out_h_r <= hd_r + dh_r;
    end
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      prev_stamp_r <= '0;
      prev_lin_r   <= '0;
      prev_ang_r   <= '0;
      x_r          <= '0;
      y_r          <= '0;
      hd_r         <= '0;
    end else begin
      if (state_r == S_UPD && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.is_twist) begin
              state_r <= S_MUL;
            end else begin
              x_r        <= q_item.is_set ? q_item.set_x : 32'd0;
              y_r        <= q_item.is_set ? q_item.set_y : 32'd0;
              hd_r       <= q_item.is_set ? q_item.set_heading : 16'd0;
              prev_lin_r <= '0;
              prev_ang_r <= '0;
            end
          end
        end
        S_MUL:  state_r <= S_DST;
        S_DST:  state_r <= S_DIV;
        S_DIV:  if (div_done) state_r <= S_ANG;
        S_ANG:  state_r <= S_CORD;
        S_CORD: if (cor_done) state_r <= S_PROD;
        S_PROD: state_r <= S_UPD;
        S_UPD: begin
          if (!out_valid_r || out_ready) begin
            x_r          <= x_r + rx[47:16];
            y_r          <= y_r + ry[47:16];
            hd_r         <= hd_r + dh_r;
            prev_stamp_r <= stamp_r;
            prev_lin_r   <= lin_r;
            prev_ang_r   <= ang_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/planar_odometry_integrator_top.sv
// Planar odometry integrator, top level. A twist item goes from the queue head
// through the /1e6 divider and the CORDIC to its beat; the back end holds one item
// at a time, so it takes the next twist only after the last one's result is
// registered. Set/reset pose items load the pose directly.
// Synchronous active-low reset zeroes pose, stored twist, timestamp and method;
// the two-deep input queue empties.
module planar_odometry_integrator_top import odo_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  odo_in_if.sink      in_twist,
  odo_out_if.source   out_pose,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic       method_r;
  logic       q_valid, q_pop;
  odo_item_t  in_item, q_item;
  logic [31:0] ox, oy;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_METHOD) ? {31'b0, method_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_METHOD) begin
      method_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    in_item.is_twist     = (in_twist.cmd == CMD_TWIST);
    in_item.is_set       = (in_twist.cmd == CMD_SET);
    in_item.stamp_us     = in_twist.stamp_us;
    in_item.lin_velocity = in_twist.lin_velocity;
    in_item.ang_velocity = in_twist.ang_velocity;
    in_item.set_x        = in_twist.set_x;
    in_item.set_y        = in_twist.set_y;
    in_item.set_heading  = in_twist.set_heading;
  end

  odo_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_twist.valid),
    .in_ready (in_twist.ready),
    .in_cmd   (in_twist.cmd),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  odo_back #(.STEPS(CORDIC_STEPS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .method    (method_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_pose.valid),
    .out_ready (out_pose.ready),
    .out_x     (ox),
    .out_y     (oy),
    .out_h     (out_pose.heading)
  );

  assign out_pose.pos_x = $signed(ox);
  assign out_pose.pos_y = $signed(oy);

endmodule

FILE: rtl/odo_checker.sv
// Port-level checks for the odometry integrator, bound to the top level.
// Depends on planar_odometry_integrator_top.
module odo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

  a_prdata: assert property (@(posedge clk) cfg_prdata[31:1] == 31'd0)
    else $error("unused register bits set");

endmodule

bind planar_odometry_integrator_top odo_checker u_odo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_pose.valid),
  .out_ready  (out_pose.ready),
  .cfg_prdata (cfg_prdata),
  .cfg_pready (cfg_pready)
);

FILE: tb/sv/testbench.sv
// Self-checking bench for planar_odometry_integrator_top: directed table, then random items
// over both integration rules, checked against an in-bench fixed-point pose predictor.
// Depends on rtl/odo_pkg.sv, rtl/odo_ifs.sv and rtl/planar_odometry_integrator_top.sv.
module testbench;
  import odo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]         cmd;
    bit [31:0]          stamp;
    bit signed [23:0]   lin;
    bit signed [23:0]   ang;
    bit signed [31:0]   sx;
    bit signed [31:0]   sy;
    bit [15:0]          sh;
  } twist_t;

  typedef struct {
    bit [31:0] x;
    bit [31:0] y;
    bit [15:0] hdg;
  } pose_t;

  typedef struct {
    twist_t s;
    bit     typed;
    pose_t  p;
  } row_t;

  localparam int RAND_ITEMS = 1750;
  localparam int QUIET_TAIL = 150;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 600;
  localparam longint US_PER_S = 1000000;
  localparam int STEPS = 16;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  odo_in_if in_if();
  odo_out_if out_if();

  planar_odometry_integrator_top dut (
    .clk(clk), .rst_n(rst_n), .in_twist(in_if.sink), .out_pose(out_if.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #2 clk = ~clk;

  // predictor state
  bit [31:0]        odo_stamp;
  bit signed [23:0] odo_lin, odo_ang;
  bit [31:0]        pose_x, pose_y;
  bit [15:0]        pose_hdg;
  bit               method_q;

  pose_t pose_due[$];
  int    errors;
  int    beats;
  bit    quiet;
  bit    hold_done;

  const longint atan_q32[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint div_nearest(input longint num, input longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic void sin_cos_q16(input bit [15:0] ang, output longint c, output longint s);
    longint x, y, z, xs, ys;
    x = 652032874;
    y = 0;
    z = longint'(ang[13:0]) << 16;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_q32[i];
      end else begin
        x += ys; y -= xs; z += atan_q32[i];
      end
    end
    x = (x + 8192) >>> 14;
    y = (y + 8192) >>> 14;
    case (ang[15:14])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic bit advance_pose(input twist_t t, output pose_t p);
    bit [31:0] dt;
    longint pv, pw, d, dh, c, s, dx, dy, half;
    bit [15:0] ang;
    if (t.cmd == CMD_SET || t.cmd == CMD_RESET) begin
      pose_x   = t.cmd == CMD_SET ? t.sx : 32'd0;
      pose_y   = t.cmd == CMD_SET ? t.sy : 32'd0;
      pose_hdg = t.cmd == CMD_SET ? t.sh : 16'd0;
      odo_lin  = '0;
      odo_ang  = '0;
      return 1'b0;
    end
    if (t.cmd != CMD_TWIST) return 1'b0;
    dt = t.stamp - odo_stamp;
    pv = longint'(odo_lin) * longint'(dt);
    pw = longint'(odo_ang) * longint'(dt);
    d  = div_nearest(pv, US_PER_S);
    dh = div_nearest(pw, US_PER_S);
    ang = pose_hdg;
    if (method_q) begin
      half = div_nearest(pw, 2 * US_PER_S);
      ang = pose_hdg + half[15:0];
    end
    sin_cos_q16(ang, c, s);
    dx = (d * c + 32768) >>> 16;
    dy = (d * s + 32768) >>> 16;
    pose_x   = pose_x + dx[31:0];
    pose_y   = pose_y + dy[31:0];
    pose_hdg = pose_hdg + dh[15:0];
    odo_stamp = t.stamp;
    odo_lin   = t.lin;
    odo_ang   = t.ang;
    p = '{pose_x, pose_y, pose_hdg};
    return 1'b1;
  endfunction

  // directed rows; typed poses only where the stored twist is zero
  const row_t directed[11] = '{
    '{'{CMD_TWIST, 32'd0, 24'sh7FFFFF, 24'sh7FFFFF, 32'sd0, 32'sd0, 16'd0}, 1'b1,
      '{32'd0, 32'd0, 16'd0}},
    '{'{CMD_TWIST, 32'd1000000, 24'sd0, 24'sd0, 32'sd0, 32'sd0, 16'd0}, 1'b0,
      '{32'd0, 32'd0, 16'd0}},
    '{'{CMD_SET, 32'd0, 24'sd0, 24'sd0, 32'sh7FFFFFFF, 32'sh80000000, 16'hFFFF}, 1'b0,
      '{32'd0, 32'd0, 16'd0}},
    '{'{CMD_TWIST, 32'd5, 24'sh800000, 24'sh800000, 32'sd0, 32'sd0, 16'd0}, 1'b1,
      '{32'h7FFFFFFF, 32'h80000000, 16'hFFFF}},
    '{'{CMD_TWIST, 32'd4, 24'sd0, 24'sd0, 32'sd0, 32'sd0, 16'd0}, 1'b0,
      '{32'd0, 32'd0, 16'd0}},
    '{'{CMD_NONE, 32'hFFFFFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 32'sd1, 32'sd1, 16'd1}, 1'b0,
      '{32'd0, 32'd0, 16'd0}},
    '{'{CMD_TWIST, 32'd1004, 24'sd65536, 24'sd16384, 32'sd0, 32'sd0, 16'd0}, 1'b0,
      '{32'd0, 32'd0, 16'd0}},
    '{'{CMD_RESET, 32'd0, 24'sd0, 24'sd0, 32'sd5, 32'sd5, 16'd5}, 1'b0,
      '{32'd0, 32'd0, 16'd0}},
    '{'{CMD_TWIST, 32'd2000, 24'sd1, 24'sh7FFFFF, 32'sd0, 32'sd0, 16'd0}, 1'b1,
      '{32'd0, 32'd0, 16'd0}},
    '{'{CMD_TWIST, 32'd2000, -24'sd1, -24'sd1, 32'sd0, 32'sd0, 16'd0}, 1'b0,
      '{32'd0, 32'd0, 16'd0}},
    '{'{CMD_TWIST, 32'd102000, 24'sd0, 24'sd0, 32'sd0, 32'sd0, 16'd0}, 1'b0,
      '{32'd0, 32'd0, 16'd0}}
  };

  task automatic cfg_access(input bit wr, input bit [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {REG_METHOD[0], 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (!wr && cfg_prdata[0] != method_q)
      report($sformatf("method readback %0d, want %0d", cfg_prdata[0], method_q));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_method(input bit m);
    while (pose_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_access(1'b1, {31'd0, m});
    method_q = m;
    cfg_access(1'b0, 32'd0);
  endtask

  task automatic send_beat(input twist_t t, input bit typed, input pose_t want);
    pose_t p;
    in_if.valid <= 1'b1;
    in_if.cmd <= t.cmd;
    in_if.stamp_us <= t.stamp;
    in_if.lin_velocity <= t.lin;
    in_if.ang_velocity <= t.ang;
    in_if.set_x <= t.sx;
    in_if.set_y <= t.sy;
    in_if.set_heading <= t.sh;
    do @(posedge clk); while (!in_if.ready);
    if (advance_pose(t, p)) pose_due.push_back(typed ? want : p);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  function automatic bit signed [23:0] pick_vel();
    if ($urandom_range(0, 3) == 0) return 24'($urandom);
    return $signed(24'($urandom_range(0, 262144))) - 24'sd131072;
  endfunction

  task automatic random_run(input int n, input bit last);
    twist_t t;
    int sent, r;
    pose_t none;
    bit [31:0] last_stamp;
    sent = 0;
    none = '{0, 0, 0};
    last_stamp = odo_stamp;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      t.cmd = r < 85 ? CMD_TWIST : r < 91 ? CMD_SET : r < 95 ? CMD_RESET : CMD_NONE;
      t.stamp = $urandom_range(0, 19) == 0 ? $urandom : last_stamp + $urandom_range(0, 50000);
      t.lin = pick_vel();
      t.ang = pick_vel();
      t.sx = $urandom;
      t.sy = $urandom;
      t.sh = 16'($urandom);
      if (t.cmd == CMD_TWIST) last_stamp = t.stamp;
      if (t.cmd != CMD_NONE) sent++;
      if (last && n - sent < QUIET_TAIL) quiet = 1'b1;
      send_beat(t, 1'b0, none);
    end
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    pose_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      beats++;
      if (pose_due.size() == 0) begin
        report("pose beat with nothing expected");
      end else begin
        w = pose_due.pop_front();
        if (out_if.pos_x !== w.x)
          report($sformatf("pos_x %h, want %h", out_if.pos_x, w.x));
        if (out_if.pos_y !== w.y)
          report($sformatf("pos_y %h, want %h", out_if.pos_y, w.y));
        if (out_if.heading !== w.hdg)
          report($sformatf("heading %h, want %h", out_if.heading, w.hdg));
      end
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (quiet) begin
        out_if.ready <= 1'b1;
      end else if (!hold_done && beats >= 300) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(0, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    #5ms;
    $display("planar_odometry_integrator_top regression: fail");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    in_if.valid <= 1'b0;
    in_if.cmd <= CMD_TWIST;
    in_if.stamp_us <= '0;
    in_if.lin_velocity <= '0;
    in_if.ang_velocity <= '0;
    in_if.set_x <= '0;
    in_if.set_y <= '0;
    in_if.set_heading <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_access(1'b0, 32'd0);
    foreach (directed[i]) send_beat(directed[i].s, directed[i].typed, directed[i].p);
    in_if.valid <= 1'b0;
    @(posedge clk);

    set_method(1'b1);
    random_run(RAND_ITEMS / 3, 1'b0);
    set_method(1'b0);
    random_run(RAND_ITEMS / 3, 1'b0);
    set_method(1'b1);
    random_run(RAND_ITEMS - 2 * (RAND_ITEMS / 3), 1'b1);

    while (pose_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pose_due.size() != 0) report("expected poses never arrived");
    if (errors == 0)
      $display("planar_odometry_integrator_top regression: pass");
    else
      $display("planar_odometry_integrator_top regression: fail");
    $finish;
  end

endmodule

FILE: planar_odometry_integrator_top.f
rtl/odo_pkg.sv
rtl/odo_ifs.sv
rtl/odo_front.sv
rtl/odo_div.sv
rtl/odo_cordic.sv
rtl/odo_back.sv
rtl/planar_odometry_integrator_top.sv
rtl/odo_checker.sv
tb/sv/testbench.sv
